// ----- sv/masked_shifted_moving_average_macros.svh -----
// Assertion macros for the masked shifted moving average checker
`ifndef MASKED_SHIFTED_MOVING_AVERAGE_MACROS_SVH
`define MASKED_SHIFTED_MOVING_AVERAGE_MACROS_SVH

// same-cycle implication
`define MSMA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("msma check failed");

// next-cycle implication
`define MSMA_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("msma check failed");

`endif

// ----- sv/msma_pkg.sv -----
// Shared constants and types for the masked shifted moving average
`default_nettype none
package msma_pkg;

    localparam int MSMA_MAX_WINDOW   = 64;
    localparam int MSMA_SAMPLE_WIDTH = 16;
    localparam int MSMA_CFG_WIDTH    = 7;
    localparam logic [6:0] MSMA_WINDOW_RESET = 7'd16;
    localparam logic [5:0] MSMA_SHIFT_RESET  = 6'd0;

    typedef enum logic [0:0] {
        CFG_WINDOW = 1'b0,
        CFG_SHIFT  = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DROP_RD,
        ST_DROP_APPLY,
        ST_WRITE,
        ST_DECIDE,
        ST_EMIT_RD,
        ST_EMIT_CALC,
        ST_DIV,
        ST_OUT,
        ST_TAIL,
        ST_TAIL_APPLY,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

// ----- sv/masked_shifted_moving_average.sv -----
// Top level of the masked shifted moving average
//
// Takes one sample per transaction and returns the mean of the used samples in a
// window of window_length samples that leads the output by lead_shift samples;
// with no used sample in the window the sample itself is passed through. Each
// averaged result is computed by one shared restoring divider, one quotient bit
// per cycle (SAMPLE_WIDTH + log2(MAX_WINDOW) + 1 steps, 23 by default). The input
// stays busy until every result of an item has been handed out, so no new
// sample is taken while one is in work. Once the window is full, the oldest
// sample is dropped first. At a column end, tail results follow, each dropping
// a sample when one leaves the window. A result with no used sample in the
// window skips the divider. A stalled result holds the input busy as well.
// window_length and lead_shift are sampled at the first sample of each column.
`default_nettype none
module masked_shifted_moving_average
    import msma_pkg::*;
#(
    parameter int MAX_WINDOW   = MSMA_MAX_WINDOW,
    parameter int SAMPLE_WIDTH = MSMA_SAMPLE_WIDTH
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    input  wire logic                           use_flag,
    input  wire logic                           column_end,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      average,
    output logic                                passed_through,
    output logic                                column_done,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [0:0]                     cfg_index,
    input  wire logic [MSMA_CFG_WIDTH-1:0]      cfg_data
);

    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int NW   = $clog2(MAX_WINDOW + 1);
    localparam int DW   = NW + 1;
    localparam int SUMW = SAMPLE_WIDTH + $clog2(MAX_WINDOW) + 1;
    localparam int SW   = SAMPLE_WIDTH;

    state_t state_reg, state_next;

    logic [6:0]  win_reg;
    logic [5:0]  shift_reg;

    logic signed [SW-1:0]   x_reg;
    logic                   use_reg;
    logic                   last_reg;
    logic [NW-1:0]          n_reg;
    logic [NW-1:0]          s_reg;
    logic [NW-1:0]          pb_reg;
    logic [NW-1:0]          pos_reg;
    logic [AW-1:0]          ptr_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic [NW-1:0]          cnt_reg;
    logic [NW-1:0]          rem_reg;
    logic [DW-1:0]          back_reg;
    logic                   done_reg;
    logic                   tail_mode_reg;
    logic                   neg_reg;

    logic signed [SW-1:0]   out_avg_reg;
    logic                   out_pass_reg;
    logic                   out_done_reg;
    logic                   out_valid_reg;
    logic signed [SW-1:0]   res_reg;
    logic                   pass_reg;

    logic [NW-1:0]   n_eff;
    logic [NW-1:0]   s_eff;
    logic [7:0]      win_w;
    logic [7:0]      n_m1_w;
    logic [DW-1:0]   d_tail;
    logic [DW-1:0]   d_sel;
    logic [DW-1:0]   ptr_w;
    logic [DW-1:0]   raddr_w;
    logic [NW-1:0]   tail_w;
    logic            in_acc;
    logic            out_free;

    logic            mem_wr;
    logic            mem_rd;
    logic [AW-1:0]   mem_raddr;
    logic [SW:0]     mem_rdata;
    logic            rd_use;
    logic signed [SW-1:0] rd_sample;

    logic                 div_start;
    logic [SUMW-1:0]      div_dividend;
    logic                 div_done;
    logic [SUMW-1:0]      div_quot;
    logic [SUMW-1:0]      q_signed;

    assign win_w  = {1'b0, win_reg};
    assign n_eff  = (win_w == 8'd0) ? NW'(1) :
                    (win_w > 8'(MAX_WINDOW)) ? NW'(MAX_WINDOW) : NW'(win_w);
    assign n_m1_w = 8'(n_eff) - 8'd1;
    assign s_eff  = ({2'b00, shift_reg} > n_m1_w) ? NW'(n_m1_w) : NW'(shift_reg);

    assign d_tail = DW'(n_reg) - DW'(s_reg) + DW'(rem_reg);
    assign ptr_w  = DW'(ptr_reg);
    assign tail_w = !last_reg ? '0 : ((s_reg < pos_reg) ? s_reg : pos_reg);

    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign rd_use    = mem_rdata[SW];
    assign rd_sample = mem_rdata[SW-1:0];

    assign div_dividend = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : SUMW'(sum_reg);
    assign q_signed     = neg_reg ? (~div_quot + SUMW'(1)) : div_quot;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (pos_reg != '0 && pos_reg >= n_reg) ? ST_DROP_RD : ST_WRITE;
                end
            end
            ST_DROP_RD:    state_next = ST_DROP_APPLY;
            ST_DROP_APPLY: state_next = ST_WRITE;
            ST_WRITE:      state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (pb_reg >= s_reg)
                begin
                    state_next = ST_EMIT_RD;
                end
                else if (tail_w != '0)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_EMIT_RD:    state_next = ST_EMIT_CALC;
            ST_EMIT_CALC:  state_next = (cnt_reg == '0) ? ST_OUT : ST_DIV;
            ST_DIV:        state_next = div_done ? ST_OUT : ST_DIV;
            ST_OUT:
            begin
                if (out_free)
                begin
                    if (tail_mode_reg)
                    begin
                        state_next = (rem_reg == NW'(1)) ? ST_FINISH : ST_TAIL;
                    end
                    else
                    begin
                        state_next = (rem_reg != '0) ? ST_TAIL : ST_FINISH;
                    end
                end
            end
            ST_TAIL:
            begin
                state_next = (d_tail <= DW'(pos_reg)) ? ST_TAIL_APPLY : ST_EMIT_RD;
            end
            ST_TAIL_APPLY: state_next = ST_EMIT_RD;
            ST_FINISH:     state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        mem_wr    = 1'b0;
        mem_rd    = 1'b0;
        div_start = 1'b0;
        d_sel     = back_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_DROP_RD:
            begin
                mem_rd = 1'b1;
                d_sel  = DW'(n_reg);
            end
            ST_WRITE:
            begin
                mem_wr = 1'b1;
            end
            ST_EMIT_RD:
            begin
                mem_rd = 1'b1;
            end
            ST_EMIT_CALC:
            begin
                div_start = (cnt_reg != '0);
            end
            ST_TAIL:
            begin
                mem_rd = 1'b1;
                d_sel  = d_tail;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign raddr_w   = (ptr_w >= d_sel) ? (ptr_w - d_sel) : (ptr_w + DW'(MAX_WINDOW) - d_sel);
    assign mem_raddr = raddr_w[AW-1:0];

    msma_hist #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SW + 1)
    ) u_hist (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (ptr_reg),
        .wr_data ({use_reg, x_reg}),
        .rd_en   (mem_rd),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    msma_div #(
        .SUMW (SUMW),
        .CW   (NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_reg       <= MSMA_WINDOW_RESET;
            shift_reg     <= MSMA_SHIFT_RESET;
            n_reg         <= NW'(16 > MAX_WINDOW ? MAX_WINDOW : 16);
            s_reg         <= '0;
            pos_reg       <= '0;
            ptr_reg       <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            tail_mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_WINDOW: win_reg   <= cfg_data;
                    CFG_SHIFT:  shift_reg <= cfg_data[5:0];
                    default:    win_reg   <= win_reg;
                endcase
            end
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && pos_reg == '0)
                    begin
                        n_reg <= n_eff;
                        s_reg <= s_eff;
                    end
                    tail_mode_reg <= 1'b0;
                end
                ST_DROP_APPLY:
                begin
                    if (rd_use)
                    begin
                        sum_reg <= sum_reg - SUMW'(rd_sample);
                        if (cnt_reg != '0)
                        begin
                            cnt_reg <= cnt_reg - NW'(1);
                        end
                    end
                end
                ST_WRITE:
                begin
                    if (use_reg)
                    begin
                        sum_reg <= sum_reg + SUMW'(x_reg);
                        cnt_reg <= cnt_reg + NW'(1);
                    end
                    ptr_reg <= (ptr_reg == AW'(MAX_WINDOW - 1)) ? '0 : ptr_reg + AW'(1);
                    if (pos_reg < n_reg)
                    begin
                        pos_reg <= pos_reg + NW'(1);
                    end
                end
                ST_DECIDE:
                begin
                    rem_reg <= tail_w;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        if (tail_mode_reg)
                        begin
                            rem_reg <= rem_reg - NW'(1);
                        end
                    end
                end
                ST_TAIL:
                begin
                    tail_mode_reg <= 1'b1;
                end
                ST_TAIL_APPLY:
                begin
                    if (rd_use)
                    begin
                        sum_reg <= sum_reg - SUMW'(rd_sample);
                        if (cnt_reg != '0)
                        begin
                            cnt_reg <= cnt_reg - NW'(1);
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (last_reg)
                    begin
                        sum_reg <= '0;
                        cnt_reg <= '0;
                        pos_reg <= '0;
                        ptr_reg <= '0;
                    end
                end
                default:
                begin
                    tail_mode_reg <= tail_mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg    <= sample;
            use_reg  <= use_flag;
            last_reg <= column_end;
            pb_reg   <= pos_reg;
        end
        if (state_reg == ST_DECIDE)
        begin
            back_reg <= DW'(s_reg) + DW'(1);
            done_reg <= last_reg && (tail_w == '0);
        end
        if (state_reg == ST_TAIL)
        begin
            back_reg <= DW'(rem_reg);
            done_reg <= (rem_reg == NW'(1));
        end
        if (state_reg == ST_EMIT_CALC)
        begin
            neg_reg  <= sum_reg[SUMW-1];
            res_reg  <= rd_sample;
            pass_reg <= (cnt_reg == '0);
        end
        if (state_reg == ST_DIV && div_done)
        begin
            res_reg <= q_signed[SW-1:0];
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_avg_reg  <= res_reg;
            out_pass_reg <= pass_reg;
            out_done_reg <= done_reg;
        end
    end

    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign average        = out_avg_reg;
    assign passed_through = out_pass_reg;
    assign column_done    = out_done_reg;

endmodule
`default_nettype wire

// ----- sv/msma_div.sv -----
// Iterative restoring divider: magnitude of the window sum by the used count
`default_nettype none
module msma_div
    import msma_pkg::*;
#(
    parameter int SUMW = 23,
    parameter int CW   = 7
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [SUMW-1:0] dividend,
    input  wire logic [CW-1:0]   divisor,
    output logic                 done,
    output logic [SUMW-1:0]      quotient
);

    localparam int KW = $clog2(SUMW + 1);

    logic [KW-1:0]   cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic [SUMW-1:0] quot_reg, quot_next;
    logic [CW:0]     shifted;
    logic [CW:0]     diff;

    assign shifted = {rem_reg, quot_reg[SUMW-1]};
    assign diff    = shifted - {1'b0, divisor};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            cnt_next  = KW'(SUMW);
            rem_next  = '0;
            quot_next = dividend;
        end
        else if (cnt_reg != '0)
        begin
            if (shifted >= {1'b0, divisor})
            begin
                rem_next  = diff[CW-1:0];
                quot_next = {quot_reg[SUMW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[CW-1:0];
                quot_next = {quot_reg[SUMW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - KW'(1);
            if (cnt_reg == KW'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

// ----- sv/msma_hist.sv -----
// Sample and use-flag history ring with registered read
`default_nettype none
module msma_hist
    import msma_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 17
)
(
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- sv/msma_checker.sv -----
// Port-level checker for the masked shifted moving average, bound to the top level
`default_nettype none
`include "masked_shifted_moving_average_macros.svh"
module msma_checker
    import msma_pkg::*;
#(
    parameter int SAMPLE_WIDTH = MSMA_SAMPLE_WIDTH
)
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [SAMPLE_WIDTH-1:0] average,
    input wire logic                    passed_through,
    input wire logic                    column_done
);

    // hold a stalled result transaction
    `MSMA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(average) && $stable(passed_through) && $stable(column_done))

    // in_ready stays low after an input transaction is accepted
    `MSMA_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready ##1 !in_ready)

    // a new result appears only while an item is in work
    `MSMA_ASSERT_IMP(a_out_in_work, clk, rst_n, $rose(out_valid), !in_ready)

endmodule

bind masked_shifted_moving_average msma_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_msma_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .average        (average),
    .passed_through (passed_through),
    .column_done    (column_done)
);
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for masked_shifted_moving_average: directed, pressure and random columns
`default_nettype none
module tb_top;
    import msma_pkg::*;

    typedef struct packed {
        logic signed [15:0] average;
        logic               passed_through;
        logic               column_done;
    } avg_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] sample = '0;
    logic               use_flag = 1'b0;
    logic               column_end = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] average;
    logic               passed_through;
    logic               column_done;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    cfg_index_t         cfg_index = CFG_WINDOW;
    logic [6:0]         cfg_data = '0;

    masked_shifted_moving_average i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .sample(sample), .use_flag(use_flag), .column_end(column_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .average(average), .passed_through(passed_through), .column_done(column_done),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic signed [15:0] hist_sample [64];
    logic               hist_use [64];
    longint             win_sum;
    int                 used_cnt;
    int                 col_pos;
    int                 wr_slot;
    int                 eff_len;
    int                 eff_lead;
    logic [6:0]         len_reg;
    logic [5:0]         lead_reg;

    avg_result_t        expected_avgs [$];
    int                 mismatches = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    bit                 stall_req = 1'b0;
    int                 stall_left = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20 * 3_000_000);
        $display("masked_shifted_moving_average test failed");
        $finish;
    end

    function automatic int slot_back(int d);
        return (wr_slot + 64 - d) % 64;
    endfunction

    function automatic void drop_slot(int s);
        if (hist_use[s])
        begin
            win_sum -= hist_sample[s];
            if (used_cnt > 0) used_cnt--;
        end
    endfunction

    function automatic void push_avg(int back, bit done);
        avg_result_t r;
        if (used_cnt == 0)
        begin
            r.average = hist_sample[slot_back(back)];
            r.passed_through = 1'b1;
        end
        else
        begin
            r.average = 16'(win_sum / used_cnt);
            r.passed_through = 1'b0;
        end
        r.column_done = done;
        expected_avgs.push_back(r);
    endfunction

    function automatic void predict_averages(logic signed [15:0] x, bit u, bit e);
        int n;
        int start_pos;
        int tail;
        int d;
        if (col_pos == 0)
        begin
            n = (len_reg < 1) ? 1 : ((len_reg > 64) ? 64 : int'(len_reg));
            eff_len = n;
            eff_lead = (lead_reg > n - 1) ? n - 1 : int'(lead_reg);
        end
        start_pos = col_pos;
        if (col_pos >= eff_len) drop_slot(slot_back(eff_len));
        hist_sample[wr_slot] = x;
        hist_use[wr_slot] = u;
        if (u)
        begin
            win_sum += x;
            used_cnt++;
        end
        wr_slot = (wr_slot + 1) % 64;
        if (col_pos < eff_len) col_pos++;
        tail = e ? ((eff_lead < col_pos) ? eff_lead : col_pos) : 0;
        if (start_pos >= eff_lead) push_avg(eff_lead + 1, e && tail == 0);
        for (int k = 0; k < tail; k++)
        begin
            d = eff_len - eff_lead + tail - k;
            if (d <= col_pos) drop_slot(slot_back(d));
            push_avg(tail - k, k + 1 == tail);
        end
        if (e)
        begin
            win_sum = 0;
            used_cnt = 0;
            col_pos = 0;
            wr_slot = 0;
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        avg_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_avgs.size() == 0)
                report_mismatch("unexpected transaction, column_done", column_done, 0);
            else
            begin
                want = expected_avgs.pop_front();
                if (average !== want.average)
                    report_mismatch("average", average, want.average);
                if (passed_through !== want.passed_through)
                    report_mismatch("passed_through", passed_through, want.passed_through);
                if (column_done !== want.column_done)
                    report_mismatch("column_done", column_done, want.column_done);
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (stall_req)
            begin
                stall_left = 700;
                stall_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_sample(logic signed [15:0] x, bit u, bit e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= x;
        use_flag <= u;
        column_end <= e;
        do @(posedge clk); while (!in_ready);
        predict_averages(x, u, e);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_avgs.size() != 0);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [6:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_WINDOW) len_reg = val;
        else lead_reg = val[5:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_column(int n_items, int use_pct);
        for (int i = 0; i < n_items; i++)
            send_sample(rand_sample(), $urandom_range(99) < use_pct, i == n_items - 1);
    endtask

    task automatic test_defaults;
        send_sample(16'sh7FFF, 1'b1, 1'b0);
        send_sample(16'sh7FFF, 1'b1, 1'b0);
        send_sample(16'sh8000, 1'b1, 1'b0);
        send_sample(16'sh8000, 1'b0, 1'b0);
        send_sample(-16'sd7, 1'b1, 1'b0);
        send_sample(16'sd0, 1'b1, 1'b1);
        send_sample(16'sh1234, 1'b0, 1'b1);
    endtask

    task automatic test_register_limits;
        write_reg(CFG_WINDOW, 7'd0);
        write_reg(CFG_SHIFT, 7'd63);
        send_column(3, 50);
        write_reg(CFG_WINDOW, 7'd127);
        send_column(5, 0);
        write_reg(CFG_WINDOW, 7'd4);
        write_reg(CFG_SHIFT, 7'd2);
        send_sample(16'sh8000, 1'b0, 1'b0);
        send_sample(16'sh7FFF, 1'b0, 1'b0);
        send_sample(-16'sd1, 1'b1, 1'b0);
        // mid-column write applies from the next column
        write_reg(CFG_SHIFT, 7'd0);
        send_sample(16'sd5, 1'b0, 1'b0);
        send_sample(16'sd9, 1'b1, 1'b1);
        write_reg(CFG_WINDOW, 7'd64);
        write_reg(CFG_SHIFT, 7'h7F);
        send_column(1, 100);
    endtask

    task automatic test_pressure;
        write_reg(CFG_WINDOW, 7'd8);
        write_reg(CFG_SHIFT, 7'd3);
        send_idle_pct = 0;
        stall_req = 1'b1;
        send_column(24, 60);
        drain();
        send_column(6, 60);
        send_idle_pct = 0;
    endtask

    task automatic random_phase(int snd, int rcv, int n_items);
        int sent;
        int len;
        logic [6:0] w;
        sent = 0;
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        while (sent < n_items)
        begin
            if ($urandom_range(3) == 0)
            begin
                w = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(12, 1));
                write_reg(CFG_WINDOW, w);
                write_reg(CFG_SHIFT,
                          ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(5)));
            end
            len = ($urandom_range(7) == 0) ? $urandom_range(80, 20) : $urandom_range(12, 1);
            send_column(len, ($urandom_range(4) == 0) ? 10 : 70);
            sent += len;
        end
    endtask

    task automatic test_random;
        random_phase(36, 84, 130);
        random_phase(84, 36, 130);
        random_phase(0, 0, 130);
    endtask

    initial
    begin
        len_reg = MSMA_WINDOW_RESET;
        lead_reg = MSMA_SHIFT_RESET;
        win_sum = 0;
        used_cnt = 0;
        col_pos = 0;
        wr_slot = 0;
        eff_len = 16;
        eff_lead = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_defaults();
        test_register_limits();
        test_pressure();
        test_random();
        drain();
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("masked_shifted_moving_average test passed");
        else
            $display("masked_shifted_moving_average test failed");
        $finish;
    end
endmodule
`default_nettype wire
